// File: rtl/sdda_pkg.sv
// ---------------------------------------------------------------------------
// sdda_pkg: shared types and constants for the stroke DDA interpolator
// Coordinate and fixed-point widths, result flag codes, sequencer states,
// and the saturation and pixel-truncation helpers used by the datapath.
// ---------------------------------------------------------------------------
package sdda_pkg;

    // Field and fixed-point widths
    localparam int COORD_BITS   = 16;                 // whole-pixel coordinate
    localparam int FRAC_BITS    = 8;                  // fraction bits of the pen
    localparam int PEN_BITS     = COORD_BITS + FRAC_BITS;
    localparam int DIFF_BITS    = PEN_BITS + 1;       // pen-to-point difference
    localparam int DIV_BITS     = PEN_BITS + 2;       // rounded slope dividend
    localparam int SUM_BITS     = PEN_BITS + 3;       // pen plus increment
    localparam int PIX_BITS     = COORD_BITS + 1;     // whole-pixel delta
    localparam int BOX_SUM_BITS = COORD_BITS + 2;     // pixel plus twice radius
    localparam int RADIUS_BITS  = 8;
    localparam int INK_BITS     = 32;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

    // One whole pixel in pen units
    localparam logic signed [SUM_BITS-1:0] PEN_UNIT = SUM_BITS'(2 ** FRAC_BITS);

    localparam logic signed [PEN_BITS-1:0] PEN_MIN = {1'b1, {(PEN_BITS-1){1'b0}}};
    localparam logic signed [PEN_BITS-1:0] PEN_MAX = {1'b0, {(PEN_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    // Event codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    // Result flags
    typedef struct packed {
        logic dot_valid;
        logic accepted;
        logic too_long;
    } flags_t;

    localparam flags_t FLAGS_DOT      = '{dot_valid: 1'b1, accepted: 1'b1, too_long: 1'b0};
    localparam flags_t FLAGS_REPEAT   = '{dot_valid: 1'b0, accepted: 1'b0, too_long: 1'b0};
    localparam flags_t FLAGS_TOO_LONG = '{dot_valid: 1'b0, accepted: 1'b0, too_long: 1'b1};

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_ORIENT,
        S_ROUND,
        S_DIVIDE,
        S_SLOPE,
        S_STEP,
        S_BORDER,
        S_EMIT,
        S_REPORT
    } state_t;

    // Saturate a widened pen sum back to the pen range
    function automatic logic signed [PEN_BITS-1:0] sat_pen(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [SUM_BITS-PEN_BITS:0] high_bits;
        high_bits = v[SUM_BITS-1:PEN_BITS-1];
        if ((&high_bits) || !(|high_bits))
            return v[PEN_BITS-1:0];
        else if (v[SUM_BITS-1])
            return PEN_MIN;
        else
            return PEN_MAX;
    endfunction

    // Saturate a widened box border back to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [BOX_SUM_BITS-1:0] v
    );
        logic [BOX_SUM_BITS-COORD_BITS:0] high_bits;
        high_bits = v[BOX_SUM_BITS-1:COORD_BITS-1];
        if ((&high_bits) || !(|high_bits))
            return v[COORD_BITS-1:0];
        else if (v[BOX_SUM_BITS-1])
            return COORD_MIN;
        else
            return COORD_MAX;
    endfunction

    // Whole pixels of a pen coordinate, truncated toward zero
    function automatic logic signed [COORD_BITS-1:0] pen_to_pixel(
        input logic signed [PEN_BITS-1:0] pen
    );
        logic signed [COORD_BITS-1:0] pix;
        pix = pen[PEN_BITS-1:FRAC_BITS];
        if (pen[PEN_BITS-1] && (|pen[FRAC_BITS-1:0]))
            pix = pix + COORD_BITS'(1);
        return pix;
    endfunction

endpackage

// File: rtl/stroke_dda_interpolator_unit.sv
// ---------------------------------------------------------------------------
// stroke_dda_interpolator_unit: pen stroke to dot interpolator
// Turns start and add pen events into dots along the stroke with a DDA walk,
// tracking the pen position in fixed point and the stroke bounding box.
// ---------------------------------------------------------------------------
//
// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+--------------------------------------
// in      | in  | in_valid / in_stall  | operation point_x point_y radius ink
//         |     |                      | replay
// out     | out | out_valid / out_stall| dot_x dot_y dot_radius dot_ink
//         |     |                      | dot_valid accepted too_long last box_*
//
// A start event or a repeated point goes from the delta state to its report, a
// too-long segment from the orient state. A segment of n dots runs the bit-serial
// restoring divider forming the slope, then two states per dot in the step
// loop (border, then box update with output load and the next pen step).
// Reset (rst_n low) clears the pen and box to zero and empties the output.
// While out_stall holds the output register the sequencer waits in place;
// in_stall is high from the transfer of an event until its last result loads.
// ---------------------------------------------------------------------------
module stroke_dda_interpolator_unit #(
    parameter int MAX_STEPS = 64
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // Pen event channel
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic                                       operation,
    input  logic signed [sdda_pkg::COORD_BITS-1:0]     point_x,
    input  logic signed [sdda_pkg::COORD_BITS-1:0]     point_y,
    input  logic        [sdda_pkg::RADIUS_BITS-1:0]    radius,
    input  logic        [sdda_pkg::INK_BITS-1:0]       ink,
    input  logic                                       replay,
    // Dot result channel
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [sdda_pkg::PEN_BITS-1:0]       dot_x,
    output logic signed [sdda_pkg::PEN_BITS-1:0]       dot_y,
    output logic        [sdda_pkg::RADIUS_BITS-1:0]    dot_radius,
    output logic        [sdda_pkg::INK_BITS-1:0]       dot_ink,
    output logic                                       dot_valid,
    output logic                                       accepted,
    output logic                                       too_long,
    output logic                                       last,
    output logic signed [sdda_pkg::COORD_BITS-1:0]     box_left,
    output logic signed [sdda_pkg::COORD_BITS-1:0]     box_top,
    output logic signed [sdda_pkg::COORD_BITS-1:0]     box_right,
    output logic signed [sdda_pkg::COORD_BITS-1:0]     box_bottom
);

    import sdda_pkg::*;

    localparam int STEP_BITS = $clog2(MAX_STEPS + 1);
    localparam int REM_BITS  = STEP_BITS + 2;

    // Sequencer
    state_t state_reg;
    state_t state_next;

    // Captured event
    logic                           op_reg;
    logic signed [COORD_BITS-1:0]   px_reg;
    logic signed [COORD_BITS-1:0]   py_reg;
    logic [RADIUS_BITS-1:0]         radius_reg;
    logic [INK_BITS-1:0]            ink_reg;
    logic                           replay_reg;

    // Pen and bounding box state
    logic signed [PEN_BITS-1:0]     pen_x_reg;
    logic signed [PEN_BITS-1:0]     pen_y_reg;
    logic signed [COORD_BITS-1:0]   left_edge_reg;
    logic signed [COORD_BITS-1:0]   top_edge_reg;
    logic signed [COORD_BITS-1:0]   right_edge_reg;
    logic signed [COORD_BITS-1:0]   bottom_edge_reg;

    // Segment set-up
    logic signed [DIFF_BITS-1:0]    diff_x_reg;
    logic signed [DIFF_BITS-1:0]    diff_y_reg;
    logic signed [PIX_BITS-1:0]     pix_x_reg;
    logic signed [PIX_BITS-1:0]     pix_y_reg;
    logic                           xmajor_reg;
    logic [STEP_BITS-1:0]           dmaj_reg;
    logic [DIFF_BITS-1:0]           mag_reg;
    logic                           minor_neg_reg;
    flags_t                         flags_reg;

    // Divider and step loop
    logic [DIV_BITS-1:0]            div_q_reg;
    logic [REM_BITS-2:0]            div_rem_reg;
    logic [DIV_CNT_BITS-1:0]        div_cnt_reg;
    logic signed [DIV_BITS-1:0]     slope_reg;
    logic [STEP_BITS-1:0]           step_cnt_reg;
    logic                           right_reg;
    logic                           down_reg;
    logic signed [COORD_BITS-1:0]   bx_reg;
    logic signed [COORD_BITS-1:0]   by_reg;

    // Output register
    logic                           out_valid_reg;
    logic signed [PEN_BITS-1:0]     dot_x_reg;
    logic signed [PEN_BITS-1:0]     dot_y_reg;
    logic [RADIUS_BITS-1:0]         dot_radius_reg;
    logic [INK_BITS-1:0]            dot_ink_reg;
    logic                           dot_valid_reg;
    logic                           accepted_reg;
    logic                           too_long_reg;
    logic                           last_reg;
    logic signed [COORD_BITS-1:0]   box_left_reg;
    logic signed [COORD_BITS-1:0]   box_top_reg;
    logic signed [COORD_BITS-1:0]   box_right_reg;
    logic signed [COORD_BITS-1:0]   box_bottom_reg;

    // Combinational datapath
    logic                           out_free;
    logic                           load_report;
    logic                           load_dot;
    logic signed [PEN_BITS-1:0]     fx_w;
    logic signed [PEN_BITS-1:0]     fy_w;
    logic signed [COORD_BITS-1:0]   pen_pix_x_w;
    logic signed [COORD_BITS-1:0]   pen_pix_y_w;
    logic signed [DIFF_BITS-1:0]    diff_x_w;
    logic signed [DIFF_BITS-1:0]    diff_y_w;
    logic signed [PIX_BITS-1:0]     pix_x_w;
    logic signed [PIX_BITS-1:0]     pix_y_w;
    logic                           same_w;
    logic signed [BOX_SUM_BITS-1:0] twice_r_w;
    logic signed [COORD_BITS-1:0]   start_right_w;
    logic signed [COORD_BITS-1:0]   start_bottom_w;
    logic signed [PIX_BITS-1:0]     dx_adj_w;
    logic signed [PIX_BITS-1:0]     dy_adj_w;
    logic [PIX_BITS-1:0]            adx_w;
    logic [PIX_BITS-1:0]            ady_w;
    logic                           xmajor_w;
    logic [PIX_BITS-1:0]            dmaj_w;
    logic                           too_long_w;
    logic signed [DIFF_BITS-1:0]    minor_w;
    logic [DIFF_BITS-1:0]           mag_w;
    logic [REM_BITS-1:0]            rem_shift_w;
    logic [REM_BITS-1:0]            den_w;
    logic                           rem_ge_w;
    logic [REM_BITS-1:0]            rem_sub_w;
    logic                           div_done_w;
    logic                           right_w;
    logic                           down_w;
    logic signed [SUM_BITS-1:0]     slope_ext_w;
    logic signed [SUM_BITS-1:0]     x_inc_w;
    logic signed [SUM_BITS-1:0]     y_inc_w;
    logic signed [PEN_BITS-1:0]     x_step_w;
    logic signed [PEN_BITS-1:0]     y_step_w;
    logic signed [COORD_BITS-1:0]   bx_w;
    logic signed [COORD_BITS-1:0]   by_w;
    logic signed [COORD_BITS-1:0]   new_left_w;
    logic signed [COORD_BITS-1:0]   new_top_w;
    logic signed [COORD_BITS-1:0]   new_right_w;
    logic signed [COORD_BITS-1:0]   new_bottom_w;
    logic                           last_step_w;

    // Handshake
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Target point in pen units and deltas from the pen
    assign fx_w        = $signed({px_reg, {FRAC_BITS{1'b0}}});
    assign fy_w        = $signed({py_reg, {FRAC_BITS{1'b0}}});
    assign pen_pix_x_w = pen_to_pixel(pen_x_reg);
    assign pen_pix_y_w = pen_to_pixel(pen_y_reg);
    assign diff_x_w    = $signed({fx_w[PEN_BITS-1], fx_w})
                       - $signed({pen_x_reg[PEN_BITS-1], pen_x_reg});
    assign diff_y_w    = $signed({fy_w[PEN_BITS-1], fy_w})
                       - $signed({pen_y_reg[PEN_BITS-1], pen_y_reg});
    assign pix_x_w     = $signed({px_reg[COORD_BITS-1], px_reg})
                       - $signed({pen_pix_x_w[COORD_BITS-1], pen_pix_x_w});
    assign pix_y_w     = $signed({py_reg[COORD_BITS-1], py_reg})
                       - $signed({pen_pix_y_w[COORD_BITS-1], pen_pix_y_w});
    assign same_w      = (fx_w == pen_x_reg) && (fy_w == pen_y_reg);

    // Start box: point plus twice the radius
    assign twice_r_w      = $signed({{(BOX_SUM_BITS-RADIUS_BITS-1){1'b0}}, radius_reg, 1'b0});
    assign start_right_w  = sat_coord($signed({{2{px_reg[COORD_BITS-1]}}, px_reg}) + twice_r_w);
    assign start_bottom_w = sat_coord($signed({{2{py_reg[COORD_BITS-1]}}, py_reg}) + twice_r_w);

    // Pick the major axis; a sub-pixel move still counts as one pixel
    always_comb
    begin
        dx_adj_w = pix_x_reg;
        dy_adj_w = pix_y_reg;
        if ((diff_x_reg != '0) && (pix_x_reg == '0))
            dx_adj_w = diff_x_reg[DIFF_BITS-1] ? '1 : PIX_BITS'(1);
        if ((diff_y_reg != '0) && (pix_y_reg == '0))
            dy_adj_w = diff_y_reg[DIFF_BITS-1] ? '1 : PIX_BITS'(1);
    end

    assign adx_w      = dx_adj_w[PIX_BITS-1] ? $unsigned(-dx_adj_w) : $unsigned(dx_adj_w);
    assign ady_w      = dy_adj_w[PIX_BITS-1] ? $unsigned(-dy_adj_w) : $unsigned(dy_adj_w);
    assign xmajor_w   = (adx_w != '0) && (adx_w >= ady_w);
    assign dmaj_w     = xmajor_w ? adx_w : ady_w;
    assign too_long_w = dmaj_w > PIX_BITS'(MAX_STEPS);
    assign minor_w    = xmajor_w ? diff_y_reg : diff_x_reg;
    assign mag_w      = minor_w[DIFF_BITS-1] ? $unsigned(-minor_w) : $unsigned(minor_w);

    // Restoring divider: one quotient bit per cycle
    assign rem_shift_w = {div_rem_reg, div_q_reg[DIV_BITS-1]};
    assign den_w       = {1'b0, dmaj_reg, 1'b0};
    assign rem_ge_w    = rem_shift_w >= den_w;
    assign rem_sub_w   = rem_shift_w - den_w;
    assign div_done_w  = (div_cnt_reg == DIV_CNT_BITS'(DIV_BITS - 1));

    // Pen step: one pixel on the major axis, the slope on the minor
    assign right_w     = pen_x_reg < fx_w;
    assign down_w      = pen_y_reg < fy_w;
    assign slope_ext_w = $signed({{(SUM_BITS-DIV_BITS){slope_reg[DIV_BITS-1]}}, slope_reg});
    assign x_inc_w     = xmajor_reg ? (right_w ? PEN_UNIT : -PEN_UNIT) : slope_ext_w;
    assign y_inc_w     = xmajor_reg ? slope_ext_w : (down_w ? PEN_UNIT : -PEN_UNIT);
    assign x_step_w    = sat_pen($signed({{(SUM_BITS-PEN_BITS){pen_x_reg[PEN_BITS-1]}},
                                          pen_x_reg}) + x_inc_w);
    assign y_step_w    = sat_pen($signed({{(SUM_BITS-PEN_BITS){pen_y_reg[PEN_BITS-1]}},
                                          pen_y_reg}) + y_inc_w);

    // Dot border in the direction of travel
    assign bx_w = sat_coord($signed({{(BOX_SUM_BITS-COORD_BITS){pen_pix_x_w[COORD_BITS-1]}},
                                     pen_pix_x_w}) + (right_reg ? twice_r_w : '0));
    assign by_w = sat_coord($signed({{(BOX_SUM_BITS-COORD_BITS){pen_pix_y_w[COORD_BITS-1]}},
                                     pen_pix_y_w}) + (down_reg ? twice_r_w : '0));

    // Stretched box, held when the event is a replay
    assign new_left_w   = (!replay_reg && (bx_reg < left_edge_reg))   ? bx_reg : left_edge_reg;
    assign new_right_w  = (!replay_reg && (bx_reg > right_edge_reg))  ? bx_reg : right_edge_reg;
    assign new_top_w    = (!replay_reg && (by_reg < top_edge_reg))    ? by_reg : top_edge_reg;
    assign new_bottom_w = (!replay_reg && (by_reg > bottom_edge_reg)) ? by_reg : bottom_edge_reg;

    assign last_step_w = ((step_cnt_reg + STEP_BITS'(1)) == dmaj_reg);

    // Next state and output loads
    always_comb
    begin
        state_next  = state_reg;
        load_report = 1'b0;
        load_dot    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DELTA;
            end
            S_DELTA:
            begin
                if ((op_reg == OP_START) || same_w)
                    state_next = S_REPORT;
                else
                    state_next = S_ORIENT;
            end
            S_ORIENT:
            begin
                state_next = too_long_w ? S_REPORT : S_ROUND;
            end
            S_ROUND:
            begin
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (div_done_w)
                    state_next = S_SLOPE;
            end
            S_SLOPE:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                state_next = S_BORDER;
            end
            S_BORDER:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load_dot   = 1'b1;
                    state_next = last_step_w ? S_IDLE : S_BORDER;
                end
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    load_report = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Pen, box and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg       <= '0;
            pen_y_reg       <= '0;
            left_edge_reg   <= '0;
            top_edge_reg    <= '0;
            right_edge_reg  <= '0;
            bottom_edge_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // drop the result once transferred, raise it when one loads
            if (load_report || load_dot)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // place the pen and reset the box on a start event
            if ((state_reg == S_DELTA) && (op_reg == OP_START))
            begin
                pen_x_reg       <= fx_w;
                pen_y_reg       <= fy_w;
                left_edge_reg   <= px_reg;
                top_edge_reg    <= py_reg;
                right_edge_reg  <= start_right_w;
                bottom_edge_reg <= start_bottom_w;
            end

            // first pen step of a segment
            if (state_reg == S_STEP)
            begin
                pen_x_reg <= x_step_w;
                pen_y_reg <= y_step_w;
            end

            // commit the box; advance the pen, or snap it to the point at the end
            if (load_dot)
            begin
                left_edge_reg   <= new_left_w;
                top_edge_reg    <= new_top_w;
                right_edge_reg  <= new_right_w;
                bottom_edge_reg <= new_bottom_w;
                if (last_step_w)
                begin
                    pen_x_reg <= fx_w;
                    pen_y_reg <= fy_w;
                end
                else
                begin
                    pen_x_reg <= x_step_w;
                    pen_y_reg <= y_step_w;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                // hold the event on transfer
                if (in_valid)
                begin
                    op_reg     <= operation;
                    px_reg     <= point_x;
                    py_reg     <= point_y;
                    radius_reg <= radius;
                    ink_reg    <= ink;
                    replay_reg <= replay;
                end
            end
            S_DELTA:
            begin
                diff_x_reg <= diff_x_w;
                diff_y_reg <= diff_y_w;
                pix_x_reg  <= pix_x_w;
                pix_y_reg  <= pix_y_w;
                flags_reg  <= (op_reg == OP_START) ? FLAGS_DOT : FLAGS_REPEAT;
            end
            S_ORIENT:
            begin
                xmajor_reg    <= xmajor_w;
                dmaj_reg      <= dmaj_w[STEP_BITS-1:0];
                mag_reg       <= mag_w;
                minor_neg_reg <= minor_w[DIFF_BITS-1];
                flags_reg     <= FLAGS_TOO_LONG;
            end
            S_ROUND:
            begin
                // round to nearest: (2 * |minor| + major) / (2 * major)
                div_q_reg   <= {mag_reg, 1'b0} + DIV_BITS'(dmaj_reg);
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
            end
            S_DIVIDE:
            begin
                div_q_reg   <= {div_q_reg[DIV_BITS-2:0], rem_ge_w};
                div_rem_reg <= rem_ge_w ? rem_sub_w[REM_BITS-2:0] : rem_shift_w[REM_BITS-2:0];
                div_cnt_reg <= div_cnt_reg + DIV_CNT_BITS'(1);
            end
            S_SLOPE:
            begin
                slope_reg    <= minor_neg_reg ? (DIV_BITS'(0) - div_q_reg) : div_q_reg;
                step_cnt_reg <= '0;
            end
            S_STEP:
            begin
                right_reg <= right_w;
                down_reg  <= down_w;
            end
            S_BORDER:
            begin
                bx_reg <= bx_w;
                by_reg <= by_w;
            end
            S_EMIT:
            begin
                // advance to the next dot
                if (out_free && !last_step_w)
                begin
                    right_reg    <= right_w;
                    down_reg     <= down_w;
                    step_cnt_reg <= step_cnt_reg + STEP_BITS'(1);
                end
            end
            default:
            begin
            end
        endcase

        // Load the output register
        if (load_report || load_dot)
        begin
            dot_x_reg      <= pen_x_reg;
            dot_y_reg      <= pen_y_reg;
            dot_radius_reg <= radius_reg;
            dot_ink_reg    <= ink_reg;
            dot_valid_reg  <= load_dot ? FLAGS_DOT.dot_valid : flags_reg.dot_valid;
            accepted_reg   <= load_dot ? FLAGS_DOT.accepted  : flags_reg.accepted;
            too_long_reg   <= load_dot ? FLAGS_DOT.too_long  : flags_reg.too_long;
            last_reg       <= load_report || last_step_w;
            box_left_reg   <= load_dot ? new_left_w   : left_edge_reg;
            box_top_reg    <= load_dot ? new_top_w    : top_edge_reg;
            box_right_reg  <= load_dot ? new_right_w  : right_edge_reg;
            box_bottom_reg <= load_dot ? new_bottom_w : bottom_edge_reg;
        end
    end

    // Output ports
    assign out_valid  = out_valid_reg;
    assign dot_x      = dot_x_reg;
    assign dot_y      = dot_y_reg;
    assign dot_radius = dot_radius_reg;
    assign dot_ink    = dot_ink_reg;
    assign dot_valid  = dot_valid_reg;
    assign accepted   = accepted_reg;
    assign too_long   = too_long_reg;
    assign last       = last_reg;
    assign box_left   = box_left_reg;
    assign box_top    = box_top_reg;
    assign box_right  = box_right_reg;
    assign box_bottom = box_bottom_reg;

`ifndef NO_ASSERTIONS
    // Divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE) |-> ({1'b0, div_rem_reg} < den_w))
    else $error("divider remainder not below divisor");

    // A segment that reaches the divider has at least one step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (dmaj_reg != '0))
    else $error("segment with zero major steps");

    // Step count stays inside the segment during the dot loop
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_BORDER) || (state_reg == S_EMIT)) |-> (step_cnt_reg < dmaj_reg))
    else $error("step count ran past the segment");

    // A rejected segment carries no dot and closes its event
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && too_long_reg) |-> (!dot_valid_reg && !accepted_reg && last_reg))
    else $error("too-long result with a dot or not last");
`endif

endmodule

// File: dv/stroke_dda_dot_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stroke_dda_dot_checker: dot stream checker for the stroke DDA interpolator
// Watches the pen event and dot channels. Each accepted pen event is run
// through an independent model of the pen walk and the bounding box, and every
// dot transfer is compared field by field with the oldest outstanding dot.
// ---------------------------------------------------------------------------
module stroke_dda_dot_checker #(
    parameter int STEP_LIMIT = 64
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    input  logic                                       in_stall,
    input  logic                                       operation,
    input  logic signed [sdda_pkg::COORD_BITS-1:0]     point_x,
    input  logic signed [sdda_pkg::COORD_BITS-1:0]     point_y,
    input  logic        [sdda_pkg::RADIUS_BITS-1:0]    radius,
    input  logic        [sdda_pkg::INK_BITS-1:0]       ink,
    input  logic                                       replay,
    input  logic                                       out_valid,
    input  logic                                       out_stall,
    input  logic signed [sdda_pkg::PEN_BITS-1:0]       dot_x,
    input  logic signed [sdda_pkg::PEN_BITS-1:0]       dot_y,
    input  logic        [sdda_pkg::RADIUS_BITS-1:0]    dot_radius,
    input  logic        [sdda_pkg::INK_BITS-1:0]       dot_ink,
    input  logic                                       dot_valid,
    input  logic                                       accepted,
    input  logic                                       too_long,
    input  logic                                       last,
    input  logic signed [sdda_pkg::COORD_BITS-1:0]     box_left,
    input  logic signed [sdda_pkg::COORD_BITS-1:0]     box_top,
    input  logic signed [sdda_pkg::COORD_BITS-1:0]     box_right,
    input  logic signed [sdda_pkg::COORD_BITS-1:0]     box_bottom,
    output int                                         mismatch_count,
    output int                                         dots_waiting
);
    import sdda_pkg::*;

    localparam longint PEN_ONE = longint'(1) << FRAC_BITS;

    // One dot transfer, in port order
    typedef struct packed {
        logic [PEN_BITS-1:0]    x;
        logic [PEN_BITS-1:0]    y;
        logic [RADIUS_BITS-1:0] radius;
        logic [INK_BITS-1:0]    ink;
        flags_t                 flags;
        logic                   last;
        logic [COORD_BITS-1:0]  box_l, box_t, box_r, box_b;
    } dot_rec_t;

    // Model state: pen in fixed point, box in whole pixels
    logic signed [PEN_BITS-1:0]   pos_x, pos_y;
    logic signed [COORD_BITS-1:0] ext_l, ext_t, ext_r, ext_b;
    dot_rec_t                     dots_due[$];

    function automatic longint saturate(input longint v, input int bits);
        longint hi, lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Whole pixels, truncated toward zero
    function automatic longint whole_px(input longint v);
        return v / PEN_ONE;
    endfunction

    // Report one mismatch on a line of its own and count it
    task automatic flag_error(input string msg);
        $display("[%0t] dot mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [INK_BITS-1:0] seen_v,
                               input logic [INK_BITS-1:0] due_v);
        if (seen_v !== due_v)
            flag_error($sformatf("%s got %0h, expected %0h", name, seen_v, due_v));
    endtask

    task automatic queue_dot(input logic [RADIUS_BITS-1:0] rad,
                             input logic [INK_BITS-1:0] colour,
                             input flags_t fl, input logic fin);
        dot_rec_t d;
        d = {pos_x, pos_y, rad, colour, fl, fin, ext_l, ext_t, ext_r, ext_b};
        dots_due = {dots_due, d};
    endtask

    // Work out the dots of one pen event and advance the pen and box
    task automatic plot_pen_event(input logic op,
                                  input logic signed [COORD_BITS-1:0] pt_x,
                                  input logic signed [COORD_BITS-1:0] pt_y,
                                  input logic [RADIUS_BITS-1:0] rad,
                                  input logic [INK_BITS-1:0] colour,
                                  input logic rep);
        longint px, py, fx, fy, cx, cy, dx, dy, adx, ady;
        longint dmaj, dmin, slope, bx, by, twice_r;
        logic   x_major, heading_right, heading_down;
        px      = saturate(longint'(pt_x), COORD_BITS);
        py      = saturate(longint'(pt_y), COORD_BITS);
        fx      = px * PEN_ONE;
        fy      = py * PEN_ONE;
        twice_r = 2 * longint'(rad);

        // Start: place the pen, reset the box, one dot
        if (op == OP_START) begin
            pos_x = PEN_BITS'(saturate(fx, PEN_BITS));
            pos_y = PEN_BITS'(saturate(fy, PEN_BITS));
            ext_l = COORD_BITS'(px);
            ext_t = COORD_BITS'(py);
            ext_r = COORD_BITS'(saturate(px + twice_r, COORD_BITS));
            ext_b = COORD_BITS'(saturate(py + twice_r, COORD_BITS));
            queue_dot(rad, colour, FLAGS_DOT, 1'b1);
            return;
        end

        // Drop a point that repeats the pen position
        cx = longint'(pos_x);
        cy = longint'(pos_y);
        if (cx == fx && cy == fy) begin
            queue_dot(rad, colour, FLAGS_REPEAT, 1'b1);
            return;
        end

        // Pick the major axis from whole-pixel deltas
        dx = px - whole_px(cx);
        dy = py - whole_px(cy);
        if (cx != fx && dx == 0)
            dx = (cx < fx) ? 1 : -1;
        if (cy != fy && dy == 0)
            dy = (cy < fy) ? 1 : -1;
        adx     = (dx < 0) ? -dx : dx;
        ady     = (dy < 0) ? -dy : dy;
        x_major = (adx != 0) && (adx >= ady);
        dmaj    = x_major ? adx : ady;
        dmin    = x_major ? (fy - cy) : (fx - cx);

        // Reject an over-long segment, state held
        if (dmaj > STEP_LIMIT) begin
            queue_dot(rad, colour, FLAGS_TOO_LONG, 1'b1);
            return;
        end

        // Slope rounded to nearest, ties away from zero
        slope = (2 * ((dmin < 0) ? -dmin : dmin) + dmaj) / (2 * dmaj);
        if (dmin < 0)
            slope = -slope;

        // Walk the major axis one pixel per dot
        for (longint k = 0; k < dmaj; k++) begin
            heading_right = (cx < fx);
            heading_down  = (cy < fy);
            if (x_major) begin
                cx = saturate(cx + (heading_right ? PEN_ONE : -PEN_ONE), PEN_BITS);
                cy = saturate(cy + slope, PEN_BITS);
            end else begin
                cy = saturate(cy + (heading_down ? PEN_ONE : -PEN_ONE), PEN_BITS);
                cx = saturate(cx + slope, PEN_BITS);
            end
            pos_x = PEN_BITS'(cx);
            pos_y = PEN_BITS'(cy);
            if (!rep) begin
                bx = saturate(whole_px(cx) + (heading_right ? twice_r : 0), COORD_BITS);
                by = saturate(whole_px(cy) + (heading_down ? twice_r : 0), COORD_BITS);
                if (bx < longint'(ext_l))
                    ext_l = COORD_BITS'(bx);
                if (bx > longint'(ext_r))
                    ext_r = COORD_BITS'(bx);
                if (by < longint'(ext_t))
                    ext_t = COORD_BITS'(by);
                if (by > longint'(ext_b))
                    ext_b = COORD_BITS'(by);
            end
            queue_dot(rad, colour, FLAGS_DOT, k == dmaj - 1);
        end

        // Snap the pen onto the point
        pos_x = PEN_BITS'(saturate(fx, PEN_BITS));
        pos_y = PEN_BITS'(saturate(fy, PEN_BITS));
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        dot_rec_t seen, want;
        if (!rst_n) begin
            pos_x = '0;
            pos_y = '0;
            ext_l = '0;
            ext_t = '0;
            ext_r = '0;
            ext_b = '0;
            dots_due.delete();
        end else begin
            // Compare the dot transfer before queueing anything new
            if (out_valid && !out_stall) begin
                seen = {dot_x, dot_y, dot_radius, dot_ink, dot_valid, accepted,
                        too_long, last, box_left, box_top, box_right, box_bottom};
                if (dots_due.size() == 0) begin
                    flag_error("dot transfer with no pen event outstanding");
                end else begin
                    want = dots_due.pop_front();
                    check_field("dot_x", INK_BITS'(seen.x), INK_BITS'(want.x));
                    check_field("dot_y", INK_BITS'(seen.y), INK_BITS'(want.y));
                    check_field("dot_radius", INK_BITS'(seen.radius),
                                INK_BITS'(want.radius));
                    check_field("dot_ink", seen.ink, want.ink);
                    check_field("dot_valid", INK_BITS'(seen.flags.dot_valid),
                                INK_BITS'(want.flags.dot_valid));
                    check_field("accepted", INK_BITS'(seen.flags.accepted),
                                INK_BITS'(want.flags.accepted));
                    check_field("too_long", INK_BITS'(seen.flags.too_long),
                                INK_BITS'(want.flags.too_long));
                    check_field("last", INK_BITS'(seen.last), INK_BITS'(want.last));
                    check_field("box_left", INK_BITS'(seen.box_l), INK_BITS'(want.box_l));
                    check_field("box_top", INK_BITS'(seen.box_t), INK_BITS'(want.box_t));
                    check_field("box_right", INK_BITS'(seen.box_r), INK_BITS'(want.box_r));
                    check_field("box_bottom", INK_BITS'(seen.box_b), INK_BITS'(want.box_b));
                end
            end
            // Predict the dots of an accepted pen event
            if (in_valid && !in_stall)
                plot_pen_event(operation, point_x, point_y, radius, ink, replay);
        end
        dots_waiting <= dots_due.size();
    end

endmodule

// File: dv/stroke_dda_interpolator_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stroke_dda_interpolator_unit_tb: testbench for the stroke DDA interpolator
// Drives directed pen events over the coordinate extremes, repeats, limit and
// over-limit segments, then random strokes under three idling mixes with one
// long output hold-off. The dot checker beside the block does the comparing.
// ---------------------------------------------------------------------------
module stroke_dda_interpolator_unit_tb;
    import sdda_pkg::*;

    localparam int STEP_LIMIT    = 64;
    localparam int RANDOM_EVENTS = 250;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 200;
    localparam int QUIET_LIMIT   = 3000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          operation;
    logic signed [COORD_BITS-1:0]  point_x, point_y;
    logic        [RADIUS_BITS-1:0] radius;
    logic        [INK_BITS-1:0]    ink;
    logic                          replay;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [PEN_BITS-1:0]    dot_x, dot_y;
    logic        [RADIUS_BITS-1:0] dot_radius;
    logic        [INK_BITS-1:0]    dot_ink;
    logic                          dot_valid, accepted, too_long, last;
    logic signed [COORD_BITS-1:0]  box_left, box_top, box_right, box_bottom;

    int                            mismatch_count;
    int                            dots_waiting;
    int                            send_idle_pct, recv_idle_pct;
    bit                            hold_request;
    // Where the pen rests once the last pen event has been handled
    logic signed [COORD_BITS-1:0]  tip_x, tip_y;

    stroke_dda_interpolator_unit #(.MAX_STEPS(STEP_LIMIT)) uut (.*);

    stroke_dda_dot_checker #(.STEP_LIMIT(STEP_LIMIT)) dot_monitor (.*);

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, or one long hold-off on request
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Stop the run if no transfer happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic signed [COORD_BITS-1:0] fit_coord(input int v);
        if (v > int'(COORD_MAX))
            return COORD_MAX;
        if (v < int'(COORD_MIN))
            return COORD_MIN;
        return COORD_BITS'(v);
    endfunction

    // Offer one pen event after a random gap and hold it until the transfer
    task automatic send_event(input logic op, input int x, input int y,
                              input logic [RADIUS_BITS-1:0] r,
                              input logic [INK_BITS-1:0] colour, input logic rep);
        logic signed [COORD_BITS-1:0] sx, sy;
        int                           span_x, span_y;
        sx = fit_coord(x);
        sy = fit_coord(y);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        point_x   <= sx;
        point_y   <= sy;
        radius    <= r;
        ink       <= colour;
        replay    <= rep;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Advance the resting point unless the segment is rejected
        span_x = int'(sx) - int'(tip_x);
        span_y = int'(sy) - int'(tip_y);
        if (span_x < 0)
            span_x = -span_x;
        if (span_y < 0)
            span_y = -span_y;
        if (op == OP_START || (span_x <= STEP_LIMIT && span_y <= STEP_LIMIT)) begin
            tip_x = sx;
            tip_y = sy;
        end
    endtask

    initial begin : stimulus
        int                     stroke_left, pick, reach, dx, dy;
        logic [RADIUS_BITS-1:0] r;
        logic                   rep;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_START;
        point_x       = '0;
        point_y       = '0;
        radius        = '0;
        ink           = '0;
        replay        = 1'b0;
        hold_request  = 1'b0;
        tip_x         = '0;
        tip_y         = '0;
        send_idle_pct = 32;
        recv_idle_pct = 46;
        stroke_left   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: repeats, axis choice, step limit, coordinate extremes
        send_event(OP_ADD,   0,      0,      8'd3,   32'h0000_0000, 1'b0);
        send_event(OP_START, 0,      0,      8'd0,   32'h0000_0000, 1'b1);
        send_event(OP_ADD,   5,      2,      8'd255, 32'hFFFF_FFFF, 1'b0);
        send_event(OP_ADD,   5,      2,      8'd7,   32'h1234_5678, 1'b0);
        send_event(OP_ADD,   3,      -10,    8'd4,   32'h5555_5555, 1'b0);
        send_event(OP_ADD,   13,     0,      8'd4,   32'hAAAA_AAAA, 1'b0);
        send_event(OP_ADD,   77,     -3,     8'd1,   32'hDEAD_BEEF, 1'b0);
        send_event(OP_ADD,   142,    -3,     8'd1,   32'h0F0F_0F0F, 1'b0);
        send_event(OP_ADD,   60,     -20,    8'd9,   32'hF0F0_F0F0, 1'b1);
        send_event(OP_ADD,   60,     44,     8'd2,   32'h8000_0001, 1'b0);
        send_event(OP_ADD,   60,     -21,    8'd2,   32'h7FFF_FFFE, 1'b0);
        send_event(OP_START, -32768, -32768, 8'd255, 32'h0000_0000, 1'b0);
        send_event(OP_ADD,   -32768, -32740, 8'd170, 32'h0000_00FF, 1'b0);
        send_event(OP_ADD,   -32730, -32767, 8'd85,  32'hFF00_0000, 1'b0);
        send_event(OP_START, 32767,  32767,  8'd255, 32'hFFFF_FFFF, 1'b0);
        send_event(OP_ADD,   32730,  32765,  8'd255, 32'h00FF_00FF, 1'b0);
        send_event(OP_ADD,   32767,  32704,  8'd128, 32'hFF00_FF00, 1'b0);
        send_event(OP_ADD,   32767,  32767,  8'd127, 32'h3C3C_3C3C, 1'b0);
        send_event(OP_START, -5,     -5,     8'd100, 32'hC3C3_C3C3, 1'b0);
        send_event(OP_ADD,   -12,    -9,     8'd100, 32'h9999_9999, 1'b0);
        send_event(OP_ADD,   20,     -9,     8'd6,   32'h6666_6666, 1'b0);
        send_event(OP_ADD,   -32768, 32767,  8'd6,   32'h1111_1111, 1'b0);
        send_event(OP_START, 1,      -1,     8'd128, 32'hEEEE_EEEE, 1'b1);
        send_event(OP_ADD,   1,      -1,     8'd128, 32'hEEEE_EEEE, 1'b0);

        // Random strokes: mostly short well-formed walks, some rejects and noise
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (n == RANDOM_EVENTS / 3) begin
                send_idle_pct = 46;
                recv_idle_pct = 32;
                hold_request  = 1'b1;
            end
            if (n == 2 * RANDOM_EVENTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            r   = ($urandom_range(3) == 0) ? RADIUS_BITS'($urandom)
                                           : RADIUS_BITS'($urandom_range(15));
            rep = ($urandom_range(7) == 0);
            if (stroke_left == 0) begin
                if ($urandom_range(3) == 0) begin
                    dx = int'($urandom_range(65535)) - 32768;
                    dy = int'($urandom_range(65535)) - 32768;
                end else begin
                    dx = int'($urandom_range(6000)) - 3000;
                    dy = int'($urandom_range(6000)) - 3000;
                end
                send_event(OP_START, dx, dy, r, $urandom, rep);
                stroke_left = $urandom_range(8, 1);
            end else begin
                pick  = $urandom_range(99);
                reach = (pick < 75) ? 12 : STEP_LIMIT;
                dx    = int'($urandom_range(2 * reach)) - reach;
                dy    = int'($urandom_range(2 * reach)) - reach;
                if (pick >= 85 && pick < 91) begin
                    dx = 0;
                    dy = 0;
                end else if (pick >= 91 && pick < 96) begin
                    reach = int'($urandom_range(400, STEP_LIMIT + 1));
                    if ($urandom_range(1))
                        reach = -reach;
                    if ($urandom_range(1))
                        dx = reach;
                    else
                        dy = reach;
                end
                if (pick >= 96)
                    send_event(logic'($urandom_range(1)),
                               int'($urandom_range(65535)) - 32768,
                               int'($urandom_range(65535)) - 32768, r, $urandom, rep);
                else
                    send_event(OP_ADD, int'(tip_x) + dx, int'(tip_y) + dy, r, $urandom, rep);
                stroke_left--;
            end
        end

        // Drain: wait for every outstanding dot, then let the block settle before the verdict
        in_valid <= 1'b0;
        @(posedge clk);
        while (dots_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
